// ----- src/assert_macros.svh -----
// Assertion macros used by the speed tracker datapath.
// Each macro expects signals named clk and rst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define EST_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked while out of reset.
`define EST_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/est_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Speed tracker package
// Types, constants and the microcode table shared by the tracker modules.
// ----------------------------------------------------------------------------
package est_pkg;

  localparam int unsigned RAW_W     = 16;
  localparam int unsigned MS_W      = 16;
  localparam int unsigned SPR_W     = 16;
  localparam int unsigned ANGLE_W   = 12;
  localparam int unsigned PROD_W    = ANGLE_W + SPR_W;
  localparam int unsigned POS_W     = 16;
  localparam int unsigned DELTA_W   = 18;
  localparam int unsigned DOUT_W    = 16;
  localparam int unsigned SPEED_W   = 19;
  localparam int unsigned SCALE_W   = 20;
  localparam int unsigned NUM_W     = POS_W + SCALE_W;
  localparam int unsigned DEN_W     = SPR_W + MS_W;
  localparam int unsigned CNT_W     = $clog2(NUM_W);
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned PC_W      = 4;

  localparam logic [RAW_W-1:0]   FAIL_CODE   = 16'hFFFF;
  localparam logic [PROD_W-1:0]  ANGLE_HALF  = PROD_W'(2048);
  localparam logic [SCALE_W-1:0] SPEED_SCALE = 20'd960000;
  localparam logic [SPEED_W-1:0] SPEED_MAX   = 19'd480000;
  localparam logic [SPR_W-1:0]   SPR_RESET   = 16'd3200;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FAIL   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOPREV = 2'd2;

  localparam logic [PC_W-1:0] PC_WAIT     = 4'd0;
  localparam logic [PC_W-1:0] PC_MAPMUL   = 4'd1;
  localparam logic [PC_W-1:0] PC_MAPRND   = 4'd2;
  localparam logic [PC_W-1:0] PC_WRAP     = 4'd3;
  localparam logic [PC_W-1:0] PC_SPDMUL   = 4'd4;
  localparam logic [PC_W-1:0] PC_DIVINIT  = 4'd5;
  localparam logic [PC_W-1:0] PC_DIVSTEP  = 4'd6;
  localparam logic [PC_W-1:0] PC_WR_OK    = 4'd7;
  localparam logic [PC_W-1:0] PC_WR_FAIL  = 4'd8;
  localparam logic [PC_W-1:0] PC_WR_FIRST = 4'd9;

  typedef enum logic [3:0] {
    OP_LOAD,
    OP_MAPMUL,
    OP_MAPRND,
    OP_WRAP,
    OP_SPDMUL,
    OP_DIVINIT,
    OP_DIVSTEP,
    OP_WR_OK,
    OP_WR_FAIL,
    OP_WR_FIRST
  } op_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_FAIL,
    C_NOPREV,
    C_NOSPEED,
    C_DIV_MORE
  } cond_t;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic            hold;
    logic [PC_W-1:0] target;
  } ucode_word_t;

  typedef struct packed {
    logic in_valid;
    logic fail;
    logic no_prev;
    logic no_speed;
    logic div_more;
    logic out_busy;
  } flags_t;

  typedef struct packed {
    op_t  op;
    logic exec;
  } ctrl_t;

  function automatic ucode_word_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_word_t w;
    case (pc)
      PC_WAIT:     w = '{op: OP_LOAD,     cond: C_NO_INPUT, hold: 1'b0, target: PC_WAIT};
      PC_MAPMUL:   w = '{op: OP_MAPMUL,   cond: C_FAIL,     hold: 1'b0, target: PC_WR_FAIL};
      PC_MAPRND:   w = '{op: OP_MAPRND,   cond: C_NOPREV,   hold: 1'b0, target: PC_WR_FIRST};
      PC_WRAP:     w = '{op: OP_WRAP,     cond: C_NEVER,    hold: 1'b0, target: PC_WAIT};
      PC_SPDMUL:   w = '{op: OP_SPDMUL,   cond: C_NOSPEED,  hold: 1'b0, target: PC_WR_OK};
      PC_DIVINIT:  w = '{op: OP_DIVINIT,  cond: C_NEVER,    hold: 1'b0, target: PC_WAIT};
      PC_DIVSTEP:  w = '{op: OP_DIVSTEP,  cond: C_DIV_MORE, hold: 1'b0, target: PC_DIVSTEP};
      PC_WR_OK:    w = '{op: OP_WR_OK,    cond: C_ALWAYS,   hold: 1'b1, target: PC_WAIT};
      PC_WR_FAIL:  w = '{op: OP_WR_FAIL,  cond: C_ALWAYS,   hold: 1'b1, target: PC_WAIT};
      PC_WR_FIRST: w = '{op: OP_WR_FIRST, cond: C_ALWAYS,   hold: 1'b1, target: PC_WAIT};
      default:     w = '{op: OP_LOAD,     cond: C_ALWAYS,   hold: 1'b0, target: PC_WAIT};
    endcase
    return w;
  endfunction

endpackage

// ----- src/est_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Speed tracker input channel
// Carries one sensor reading and its elapsed time per item.
// ----------------------------------------------------------------------------
interface est_in_if
  import est_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [RAW_W-1:0]  raw_angle;
  logic [MS_W-1:0]   elapsed_ms;

  modport source (output valid, output raw_angle, output elapsed_ms, input ready);
  modport sink   (input valid, input raw_angle, input elapsed_ms, output ready);
endinterface

// ----- src/est_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Speed tracker result channel
// Carries position, wrapped change, speed and status per item.
// ----------------------------------------------------------------------------
interface est_out_if
  import est_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [POS_W-1:0]    mapped_position;
  logic signed [DOUT_W-1:0] delta_steps;
  logic [SPEED_W-1:0]  speed_rpm_x16;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output mapped_position, output delta_steps,
                  output speed_rpm_x16, output status, input ready);
  modport sink   (input valid, input mapped_position, input delta_steps,
                  input speed_rpm_x16, input status, output ready);
endinterface

// ----- src/est_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Speed tracker sequencer
// Step counter and microcode table with conditional jumps.
// ----------------------------------------------------------------------------
module est_seq
  import est_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  flags_t flags,
  output ctrl_t  ctrl
);

  logic [PC_W-1:0] pc_r;
  logic [PC_W-1:0] pc_nxt;
  ucode_word_t     word;
  logic            take_jump;
  logic            stall;

  assign word  = ucode_rom(pc_r);
  assign stall = word.hold && flags.out_busy;

  always_comb begin
    case (word.cond)
      C_NEVER:    take_jump = 1'b0;
      C_ALWAYS:   take_jump = 1'b1;
      C_NO_INPUT: take_jump = !flags.in_valid;
      C_FAIL:     take_jump = flags.fail;
      C_NOPREV:   take_jump = flags.no_prev;
      C_NOSPEED:  take_jump = flags.no_speed;
      C_DIV_MORE: take_jump = flags.div_more;
      default:    take_jump = 1'b1;
    endcase
  end

  always_comb begin
    if (stall) begin
      pc_nxt = pc_r;
    end else if (take_jump) begin
      pc_nxt = word.target;
    end else begin
      pc_nxt = pc_r + PC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_WAIT;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign ctrl.op   = word.op;
  assign ctrl.exec = !stall;

endmodule

// ----- src/est_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Speed tracker datapath
// Angle mapping, wrap, multipliers, restoring divider and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module est_datapath
  import est_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [SPR_W-1:0] rev_steps,
  input  ctrl_t            ctrl,
  output flags_t           flags,
  est_in_if.sink           in_ch,
  est_out_if.source        out_ch
);

  logic [RAW_W-1:0]          raw_r;
  logic [MS_W-1:0]           ms_r;
  logic [PROD_W-1:0]         prod_r;
  logic [POS_W-1:0]          pos_r;
  logic signed [DELTA_W-1:0] d_r;
  logic [NUM_W-1:0]          num_r;
  logic [DEN_W-1:0]          den_r;
  logic [DEN_W-1:0]          rem_r;
  logic [SPEED_W-1:0]        quot_r;
  logic                      ovf_r;
  logic [CNT_W-1:0]          cnt_r;
  logic [POS_W-1:0]          prev_pos_r;
  logic                      prev_valid_r;
  logic                      out_valid_r;
  logic [POS_W-1:0]          mapped_r;
  logic [DOUT_W-1:0]         delta_r;
  logic [SPEED_W-1:0]        speed_r;
  logic [STATUS_W-1:0]       status_r;

  logic [PROD_W-1:0]         rnd;
  logic signed [DELTA_W-1:0] diff;
  logic signed [DELTA_W-1:0] half;
  logic signed [DELTA_W-1:0] spr_s;
  logic signed [DELTA_W-1:0] d_nxt;
  logic [NUM_W-1:0]          num_prod;
  logic [DEN_W:0]            rem2;
  logic                      ge;
  logic [DEN_W-1:0]          rem_nxt;
  logic [SPEED_W-1:0]        speed_nxt;
  logic                      accept;
  logic                      out_take;

  assign rnd   = prod_r + ANGLE_HALF;
  assign diff  = $signed({2'b00, pos_r}) - $signed({2'b00, prev_pos_r});
  assign half  = $signed({3'b000, rev_steps[SPR_W-1:1]});
  assign spr_s = $signed({2'b00, rev_steps});

  always_comb begin
    if (diff < -half) begin
      d_nxt = diff + spr_s;
    end else if (diff > half) begin
      d_nxt = diff - spr_s;
    end else begin
      d_nxt = diff;
    end
  end

  assign num_prod  = d_r[POS_W-1:0] * SPEED_SCALE;
  assign rem2      = {rem_r, num_r[NUM_W-1]};
  assign ge        = rem2 >= {1'b0, den_r};
  assign rem_nxt   = ge ? DEN_W'(rem2 - {1'b0, den_r}) : rem2[DEN_W-1:0];
  assign speed_nxt = (ovf_r || (quot_r > SPEED_MAX)) ? SPEED_MAX : quot_r;

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_take = out_valid_r && out_ch.ready;

  assign flags.in_valid = in_ch.valid;
  assign flags.fail     = raw_r == FAIL_CODE;
  assign flags.no_prev  = !prev_valid_r;
  assign flags.no_speed = d_r[DELTA_W-1] || (d_r == '0) || (ms_r == '0) ||
                          (rev_steps == '0);
  assign flags.div_more = cnt_r != '0;
  assign flags.out_busy = out_valid_r && !out_ch.ready;

  assign in_ch.ready = ctrl.op == OP_LOAD;

  always_ff @(posedge clk) begin
    if (accept) begin
      raw_r <= in_ch.raw_angle;
      ms_r  <= in_ch.elapsed_ms;
    end
    if (ctrl.exec) begin
      case (ctrl.op)
        OP_MAPMUL: begin
          prod_r <= raw_r[ANGLE_W-1:0] * rev_steps;
        end
        OP_MAPRND: begin
          pos_r <= rnd[PROD_W-1:ANGLE_W];
        end
        OP_WRAP: begin
          d_r <= d_nxt;
        end
        OP_SPDMUL: begin
          num_r  <= num_prod;
          den_r  <= rev_steps * ms_r;
          quot_r <= '0;
          ovf_r  <= 1'b0;
        end
        OP_DIVINIT: begin
          rem_r <= '0;
          cnt_r <= CNT_W'(NUM_W - 1);
        end
        OP_DIVSTEP: begin
          rem_r  <= rem_nxt;
          num_r  <= {num_r[NUM_W-2:0], 1'b0};
          quot_r <= {quot_r[SPEED_W-2:0], ge};
          ovf_r  <= ovf_r || quot_r[SPEED_W-1];
          cnt_r  <= cnt_r - CNT_W'(1);
        end
        OP_WR_OK: begin
          mapped_r <= pos_r;
          delta_r  <= d_r[DOUT_W-1:0];
          speed_r  <= speed_nxt;
          status_r <= ST_OK;
        end
        OP_WR_FAIL: begin
          mapped_r <= FAIL_CODE;
          delta_r  <= '0;
          speed_r  <= '0;
          status_r <= ST_FAIL;
        end
        OP_WR_FIRST: begin
          mapped_r <= pos_r;
          delta_r  <= '0;
          speed_r  <= '0;
          status_r <= ST_NOPREV;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      prev_valid_r <= 1'b0;
      prev_pos_r   <= '0;
    end else begin
      if (ctrl.exec && (ctrl.op == OP_WR_OK || ctrl.op == OP_WR_FAIL ||
                        ctrl.op == OP_WR_FIRST)) begin
        out_valid_r <= 1'b1;
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
      if (ctrl.exec && (ctrl.op == OP_WR_OK || ctrl.op == OP_WR_FIRST)) begin
        prev_pos_r   <= pos_r;
        prev_valid_r <= 1'b1;
      end else if (ctrl.exec && ctrl.op == OP_WR_FAIL) begin
        prev_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.mapped_position = mapped_r;
  assign out_ch.delta_steps     = delta_r;
  assign out_ch.speed_rpm_x16   = speed_r;
  assign out_ch.status          = status_r;

  `EST_ASSERT_IMP(a_speed_cap, out_valid_r, speed_r <= SPEED_MAX, "speed above cap")
  `EST_ASSERT_IMP(a_bad_zero, out_valid_r && status_r != ST_OK,
                  delta_r == '0 && speed_r == '0, "non-ok item carries motion")
  `EST_ASSERT_IMP(a_fail_pos, out_valid_r && status_r == ST_FAIL,
                  mapped_r == FAIL_CODE, "failed read without fail position")

endmodule

// ----- src/encoder_speed_tracker.sv -----
`timescale 1ns / 1ps
// The full path maps, wraps, multiplies and runs 36 one-bit-a-cycle divider steps;
// a failed read, a first sample and a zero speed jump ahead to their result write.
// A new reading is taken only after the last result is written.
// Reset: rev_steps returns to 3200, no previous sample is held, output empty.
// ----------------------------------------------------------------------------
// Encoder speed tracker
// Maps angle readings to microsteps and derives wrapped change and speed.
// ----------------------------------------------------------------------------
module encoder_speed_tracker
  import est_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  est_in_if.sink      in_ch,
  est_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [SPR_W-1:0] spr_r;
  logic             cfg_wr;
  flags_t           flags;
  ctrl_t            ctrl;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == 1'b0) ? {16'h0000, spr_r} : 32'h0000_0000;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spr_r <= SPR_RESET;
    end else if (cfg_wr && cfg_paddr[2] == 1'b0) begin
      spr_r <= cfg_pwdata[SPR_W-1:0];
    end
  end

  est_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctrl  (ctrl)
  );

  est_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .rev_steps (spr_r),
    .ctrl      (ctrl),
    .flags     (flags),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

endmodule

// ----- test/encoder_speed_tracker_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder speed tracker testbench
// Drives sensor readings through the input channel with random gaps, predicts
// position, wrapped change, speed and status for every accepted item, and
// compares each result item field by field. The revolution scale is retuned
// over the APB port between phases and read back after each write.
// ----------------------------------------------------------------------------
module encoder_speed_tracker_tb;
  import est_pkg::*;

  localparam logic [2:0] REG_REV_STEPS  = 3'd0;
  localparam int unsigned MAX_REPORTED  = 10;
  localparam int unsigned SETTLE_CYCLES = 60;

  typedef struct packed {
    logic [POS_W-1:0]    position;
    logic [DOUT_W-1:0]   delta;
    logic [SPEED_W-1:0]  speed;
    logic [STATUS_W-1:0] status;
  } speed_report_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  est_in_if  in_if ();
  est_out_if out_if ();

  encoder_speed_tracker u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_if),
    .out_ch      (out_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Tracker state as the block should hold it.
  logic [SPR_W-1:0] steps_model;
  logic [POS_W-1:0] last_position;
  logic             last_valid;

  speed_report_t reports_due[$];
  int unsigned   mismatch_count;
  bit            no_idle;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  initial begin
    #6_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic speed_report_t track_reading(input logic [RAW_W-1:0] raw,
                                                  input logic [MS_W-1:0] ms);
    speed_report_t r;
    longint        angle;
    longint        steps;
    longint        d;
    longint        half;
    longint        den;
    longint        q;
    r = '0;
    steps = steps_model;
    if (raw == FAIL_CODE) begin
      last_valid = 1'b0;
      r.position = 16'hFFFF;
      r.status = ST_FAIL;
      return r;
    end
    angle = raw[ANGLE_W-1:0];
    r.position = 16'((angle * steps + 2048) / 4096);
    if (!last_valid) begin
      r.status = ST_NOPREV;
    end else begin
      d = longint'(r.position) - longint'(last_position);
      half = steps / 2;
      if (d < -half) begin
        d = d + steps;
      end else if (d > half) begin
        d = d - steps;
      end
      r.delta = 16'(d);
      if (d > 0 && ms != '0 && steps != 0) begin
        den = steps * longint'(ms);
        q = (d * 960000) / den;
        if (q > 480000) begin
          q = 480000;
        end
        r.speed = 19'(q);
      end
      r.status = ST_OK;
    end
    last_position = r.position;
    last_valid = 1'b1;
    return r;
  endfunction

  task automatic note_mismatch(input string what, input speed_report_t want,
                               input speed_report_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTED) begin
      $write("%0t %s: expected pos %0d delta %0d speed %0d status %0d, ",
             $time, what, want.position, $signed(want.delta), want.speed, want.status);
      $display("got pos %0d delta %0d speed %0d status %0d",
               got.position, $signed(got.delta), got.speed, got.status);
    end
  endtask

  task automatic send_reading(input logic [RAW_W-1:0] raw, input logic [MS_W-1:0] ms);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_if.valid = 1'b0;
      if ($urandom_range(0, 1) == 1) begin
        do @(posedge clk); while (!in_if.ready);
      end
      repeat (gap) @(negedge clk);
    end
    in_if.valid = 1'b1;
    in_if.raw_angle = raw;
    in_if.elapsed_ms = ms;
    do @(posedge clk); while (!in_if.ready);
    reports_due.push_back(track_reading(raw, ms));
    @(negedge clk);
  endtask

  task automatic wait_reports_drained();
    in_if.valid = 1'b0;
    while (reports_due.size() != 0) @(negedge clk);
  endtask

  task automatic apb_transfer(input bit write, input logic [31:0] wdata,
                              output logic [31:0] rdata);
    cfg_psel = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite = write;
    cfg_paddr = REG_REV_STEPS;
    cfg_pwdata = wdata;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
  endtask

  task automatic check_steps_readback();
    logic [31:0] rdata;
    apb_transfer(1'b0, 32'd0, rdata);
    if (rdata[SPR_W-1:0] !== steps_model) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTED) begin
        $display("%0t rev_steps readback: expected %0d, got %0d", $time,
                 steps_model, rdata[SPR_W-1:0]);
      end
    end
  endtask

  task automatic retune_rev_steps(input logic [SPR_W-1:0] steps);
    logic [31:0] unused;
    wait_reports_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    apb_transfer(1'b1, {16'd0, steps}, unused);
    steps_model = steps;
    check_steps_readback();
  endtask

  // Result side: stalls are drawn per item and start once a result is showing.
  initial begin
    speed_report_t got;
    speed_report_t want;
    int unsigned   stall;
    out_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 4);
      if (stall != 0) begin
        out_if.ready = 1'b0;
        do @(posedge clk); while (!out_if.valid);
        @(negedge clk);
        repeat (stall - 1) @(negedge clk);
      end
      out_if.ready = 1'b1;
      do @(posedge clk); while (!(out_if.valid && out_if.ready));
      got.position = out_if.mapped_position;
      got.delta = out_if.delta_steps;
      got.speed = out_if.speed_rpm_x16;
      got.status = out_if.status;
      if (reports_due.size() == 0) begin
        note_mismatch("unexpected result", '0, got);
      end else begin
        want = reports_due.pop_front();
        if (got.position !== want.position || got.delta !== want.delta ||
            got.speed !== want.speed || got.status !== want.status) begin
          note_mismatch("result mismatch", want, got);
        end
      end
      @(negedge clk);
    end
  end

  task automatic test_register_reset();
    check_steps_readback();
  endtask

  task automatic test_default_scale_cases();
    send_reading(16'h0000, 16'd10);
    send_reading(16'h0800, 16'd10);
    send_reading(16'h0FFF, 16'd1);
    send_reading(16'h0001, 16'd1);
    send_reading(16'h0FFF, 16'd5);
    send_reading(16'h0FFF, 16'd0);
    send_reading(16'h0400, 16'd0);
    send_reading(16'hFFFF, 16'd7);
    send_reading(16'h0400, 16'd7);
    send_reading(16'hF400, 16'hFFFF);
    send_reading(16'h0C00, 16'd1);
    send_reading(16'hFFFE, 16'd1);
    send_reading(16'hFFFF, 16'd0);
    send_reading(16'hFFFF, 16'hFFFF);
    send_reading(16'h0000, 16'd0);
    send_reading(16'h0801, 16'd1);
  endtask

  task automatic test_scale_extremes();
    retune_rev_steps(16'd1);
    send_reading(16'h0000, 16'd1);
    send_reading(16'h07FF, 16'd1);
    send_reading(16'h0800, 16'd1);
    send_reading(16'h0FFF, 16'hFFFF);
    retune_rev_steps(16'hFFFF);
    send_reading(16'h0FFF, 16'd1);
    send_reading(16'h0000, 16'd1);
    send_reading(16'h0800, 16'd1);
    send_reading(16'h0FFF, 16'hFFFF);
  endtask

  task automatic test_random_rotation(input logic [SPR_W-1:0] steps, input int unsigned count);
    logic [ANGLE_W-1:0] angle;
    logic [3:0]         upper;
    logic [MS_W-1:0]    ms;
    int unsigned        pick;
    int unsigned        stride;
    retune_rev_steps(steps);
    angle = 12'($urandom_range(0, 4095));
    for (int unsigned i = 0; i < count; i++) begin
      no_idle = (i >= count / 3) && (i < count / 3 + 30);
      if (i == count / 2) begin
        wait_reports_drained();
      end
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        send_reading(FAIL_CODE, 16'($urandom_range(0, 65535)));
      end else if (pick < 10) begin
        send_reading(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
      end else begin
        stride = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 64) : $urandom_range(0, 2048);
        if ($urandom_range(0, 3) == 0) begin
          angle = angle - 12'(stride);
        end else begin
          angle = angle + 12'(stride);
        end
        upper = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) : 4'd0;
        if (pick < 14) begin
          ms = '0;
        end else if (pick < 24) begin
          ms = 16'($urandom_range(1, 65535));
        end else begin
          ms = 16'($urandom_range(1, 20));
        end
        send_reading({upper, angle}, ms);
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    no_idle = 1'b0;
    mismatch_count = 0;
    in_if.valid = 1'b0;
    in_if.raw_angle = '0;
    in_if.elapsed_ms = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    steps_model = SPR_RESET;
    last_position = '0;
    last_valid = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_register_reset();
    test_default_scale_cases();
    test_scale_extremes();
    test_random_rotation(16'd3200, 160);
    test_random_rotation(16'd1, 150);
    test_random_rotation(16'hFFFF, 160);
    test_random_rotation(16'($urandom_range(2, 65534)), 160);
    test_random_rotation(16'd200, 160);
    test_random_rotation(16'($urandom_range(1, 16)), 160);

    wait_reports_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (reports_due.size() != 0) begin
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- encoder_speed_tracker.f -----
+incdir+src
src/est_pkg.sv
src/est_in_if.sv
src/est_out_if.sv
src/est_seq.sv
src/est_datapath.sv
src/encoder_speed_tracker.sv
test/encoder_speed_tracker_tb.sv
